// ----- rtl/core/pgc_pkg.sv -----
// ============================================================================
// pgc_pkg: shared types and constants of the PID gimbal controller
// Field widths, register indexes, microcode encodings and the control store.
// ============================================================================
package pgc_pkg;

  localparam int GAIN_W   = 16;
  localparam int ANGLE_W  = 16;
  localparam int RATE_W   = 16;
  localparam int MS_W     = 10;
  localparam int ERR_W    = 17;
  localparam int ACC_W    = 40;
  localparam int DRIVE_W  = 24;
  localparam int MUL_A_W  = 17;
  localparam int MUL_B_W  = 21;
  localparam int PROD_W   = MUL_A_W + MUL_B_W;
  localparam int PSUM_W   = 34;
  localparam int WIDE_W   = 56;
  localparam int ACC_SPLIT = 20;
  localparam int CFG_IDX_W = 2;

  // Divide by 1000, eight quotient bits per step.
  localparam int DIV_RADIX_BITS = 8;
  localparam int DIV_DIGITS     = WIDE_W / DIV_RADIX_BITS;
  localparam int REM_W          = 10;
  localparam logic [REM_W:0] DIVISOR = 11'd1000;
  localparam int LOOP_W         = 3;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
  localparam logic signed [DRIVE_W-1:0] DRIVE_MAX = {1'b0, {(DRIVE_W-1){1'b1}}};
  localparam logic signed [DRIVE_W-1:0] DRIVE_MIN = {1'b1, {(DRIVE_W-1){1'b0}}};

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_P_GAIN       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_I_GAIN       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_D_GAIN       = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_ANGLE = 2'd3;

  // Multiplier operand selection.
  localparam logic [2:0] MUL_NONE   = 3'd0;
  localparam logic [2:0] MUL_ERR_MS = 3'd1;
  localparam logic [2:0] MUL_P_ERR  = 3'd2;
  localparam logic [2:0] MUL_D_RATE = 3'd3;
  localparam logic [2:0] MUL_I_LO   = 3'd4;
  localparam logic [2:0] MUL_I_HI   = 3'd5;

  // Datapath operations on the registered product and working registers.
  localparam logic [3:0] OP_NONE      = 4'd0;
  localparam logic [3:0] OP_LOAD      = 4'd1;
  localparam logic [3:0] OP_INTEG     = 4'd2;
  localparam logic [3:0] OP_PSUM_LOAD = 4'd3;
  localparam logic [3:0] OP_PSUM_ADD  = 4'd4;
  localparam logic [3:0] OP_W_LOAD    = 4'd5;
  localparam logic [3:0] OP_W_ADDHI   = 4'd6;
  localparam logic [3:0] OP_DIV_START = 4'd7;
  localparam logic [3:0] OP_DIV_STEP  = 4'd8;
  localparam logic [3:0] OP_FINISH    = 4'd9;

  // Sequencer jump kinds.
  localparam logic [1:0] JMP_NEXT     = 2'd0;
  localparam logic [1:0] JMP_WAIT_IN  = 2'd1;
  localparam logic [1:0] JMP_LOOP     = 2'd2;
  localparam logic [1:0] JMP_WAIT_OUT = 2'd3;

  localparam int STEP_W = 4;

  typedef struct packed {
    logic [2:0]        mul_sel;
    logic [3:0]        op;
    logic [1:0]        jmp;
    logic              ld_loop;
    logic [STEP_W-1:0] target;
  } ctrl_word_t;

  function automatic ctrl_word_t mk(input logic [2:0] mul_sel, input logic [3:0] op,
                                    input logic [1:0] jmp, input logic ld_loop,
                                    input logic [STEP_W-1:0] target);
    ctrl_word_t w;
    w.mul_sel = mul_sel;
    w.op      = op;
    w.jmp     = jmp;
    w.ld_loop = ld_loop;
    w.target  = target;
    return w;
  endfunction

  // Control store. Each product is consumed one step after it is issued.
  function automatic ctrl_word_t ucode(input logic [STEP_W-1:0] step);
    ctrl_word_t w;
    case (step)
      4'd0:    w = mk(MUL_NONE,   OP_LOAD,      JMP_WAIT_IN,  1'b0, 4'd0);
      4'd1:    w = mk(MUL_ERR_MS, OP_NONE,      JMP_NEXT,     1'b0, 4'd0);
      4'd2:    w = mk(MUL_P_ERR,  OP_INTEG,     JMP_NEXT,     1'b0, 4'd0);
      4'd3:    w = mk(MUL_D_RATE, OP_PSUM_LOAD, JMP_NEXT,     1'b0, 4'd0);
      4'd4:    w = mk(MUL_I_LO,   OP_PSUM_ADD,  JMP_NEXT,     1'b0, 4'd0);
      4'd5:    w = mk(MUL_I_HI,   OP_W_LOAD,    JMP_NEXT,     1'b0, 4'd0);
      4'd6:    w = mk(MUL_NONE,   OP_W_ADDHI,   JMP_NEXT,     1'b0, 4'd0);
      4'd7:    w = mk(MUL_NONE,   OP_DIV_START, JMP_NEXT,     1'b1, 4'd0);
      4'd8:    w = mk(MUL_NONE,   OP_DIV_STEP,  JMP_LOOP,     1'b0, 4'd8);
      4'd9:    w = mk(MUL_NONE,   OP_FINISH,    JMP_WAIT_OUT, 1'b0, 4'd0);
      default: w = mk(MUL_NONE,   OP_NONE,      JMP_WAIT_OUT, 1'b0, 4'd0);
    endcase
    return w;
  endfunction

endpackage

// ----- rtl/core/pgc_cfg_if.sv -----
// ============================================================================
// pgc_cfg_if: configuration write channel
// Carries a register index and the word written to it.
// ============================================================================
interface pgc_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [pgc_pkg::CFG_IDX_W-1:0]     index;
  logic [pgc_pkg::GAIN_W-1:0]        data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/core/pgc_in_if.sv -----
// ============================================================================
// pgc_in_if: sample channel
// One word per control step: angle, rate and elapsed milliseconds.
// ============================================================================
interface pgc_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [pgc_pkg::ANGLE_W-1:0]   measured_angle;
  logic signed [pgc_pkg::RATE_W-1:0]    measured_rate;
  logic [pgc_pkg::MS_W-1:0]             elapsed_ms;

  modport source (output valid, measured_angle, measured_rate, elapsed_ms, input ready);
  modport sink   (input valid, measured_angle, measured_rate, elapsed_ms, output ready);
endinterface

// ----- rtl/core/pgc_out_if.sv -----
// ============================================================================
// pgc_out_if: result channel
// One word per sample: the saturated drive and the clamp flag.
// ============================================================================
interface pgc_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [pgc_pkg::DRIVE_W-1:0]   drive_out;
  logic                                 saturated;

  modport source (output valid, drive_out, saturated, input ready);
  modport sink   (input valid, drive_out, saturated, output ready);
endinterface

// ----- rtl/core/pgc_datapath.sv -----
// ============================================================================
// pgc_datapath: PID arithmetic driven by the control word
// Shared 17x21 multiplier, integral accumulator, digit-serial divide by 1000.
// ============================================================================
module pgc_datapath (
  input  logic                                 clk,
  input  logic                                 rst,
  input  pgc_pkg::ctrl_word_t                  ctrl,
  input  logic signed [pgc_pkg::GAIN_W-1:0]    p_gain,
  input  logic signed [pgc_pkg::GAIN_W-1:0]    i_gain,
  input  logic signed [pgc_pkg::GAIN_W-1:0]    d_gain,
  input  logic signed [pgc_pkg::ANGLE_W-1:0]   target_angle,
  input  logic signed [pgc_pkg::ANGLE_W-1:0]   measured_angle,
  input  logic signed [pgc_pkg::RATE_W-1:0]    measured_rate,
  input  logic [pgc_pkg::MS_W-1:0]             elapsed_ms,
  output logic signed [pgc_pkg::DRIVE_W-1:0]   drive_next,
  output logic                                 sat_next
);

  logic signed [pgc_pkg::ERR_W-1:0]   err;
  logic [pgc_pkg::MS_W-1:0]           ms;
  logic signed [pgc_pkg::RATE_W-1:0]  rate;
  logic signed [pgc_pkg::PROD_W-1:0]  prod;
  logic signed [pgc_pkg::ACC_W-1:0]   integral_acc;
  logic                               sat;
  logic signed [pgc_pkg::PSUM_W-1:0]  psum;
  logic signed [pgc_pkg::WIDE_W-1:0]  wide;
  logic [pgc_pkg::WIDE_W-1:0]         dvd;
  logic [pgc_pkg::WIDE_W-1:0]         quo;
  logic [pgc_pkg::REM_W-1:0]          rem;
  logic                               neg;

  logic signed [pgc_pkg::MUL_A_W-1:0] mul_a;
  logic signed [pgc_pkg::MUL_B_W-1:0] mul_b;
  logic signed [pgc_pkg::ACC_W:0]     acc_sum;
  logic signed [pgc_pkg::ACC_W-1:0]   acc_next;
  logic                               acc_ovf;
  logic [pgc_pkg::WIDE_W-1:0]         dvd_next;
  logic [pgc_pkg::WIDE_W-1:0]         quo_next;
  logic [pgc_pkg::REM_W-1:0]          rem_next;
  logic signed [pgc_pkg::WIDE_W-1:0]  quot_s;
  logic signed [pgc_pkg::WIDE_W-1:0]  sum16;
  logic signed [pgc_pkg::WIDE_W-9:0]  drive_wide;
  logic                               drive_fits;

  always_comb begin
    case (ctrl.mul_sel)
      pgc_pkg::MUL_ERR_MS: begin
        mul_a = err;
        mul_b = {11'b0, ms};
      end
      pgc_pkg::MUL_P_ERR: begin
        mul_a = {p_gain[15], p_gain};
        mul_b = {{4{err[16]}}, err};
      end
      pgc_pkg::MUL_D_RATE: begin
        mul_a = {d_gain[15], d_gain};
        mul_b = {{5{rate[15]}}, rate};
      end
      pgc_pkg::MUL_I_LO: begin
        mul_a = {i_gain[15], i_gain};
        mul_b = {1'b0, integral_acc[pgc_pkg::ACC_SPLIT-1:0]};
      end
      pgc_pkg::MUL_I_HI: begin
        mul_a = {i_gain[15], i_gain};
        mul_b = {integral_acc[pgc_pkg::ACC_W-1],
                 integral_acc[pgc_pkg::ACC_W-1:pgc_pkg::ACC_SPLIT]};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Integral update with clamping to the 40-bit range.
  always_comb begin
    acc_sum = {integral_acc[pgc_pkg::ACC_W-1], integral_acc}
            + {{(pgc_pkg::ACC_W + 1 - pgc_pkg::PROD_W){prod[pgc_pkg::PROD_W-1]}}, prod};
    acc_ovf = acc_sum[pgc_pkg::ACC_W] != acc_sum[pgc_pkg::ACC_W-1];
    if (acc_ovf) begin
      acc_next = acc_sum[pgc_pkg::ACC_W] ? pgc_pkg::ACC_MIN : pgc_pkg::ACC_MAX;
    end else begin
      acc_next = acc_sum[pgc_pkg::ACC_W-1:0];
    end
  end

  // Eight restoring-division steps per cycle on a 10-bit remainder.
  always_comb begin
    logic [pgc_pkg::REM_W:0] t;
    logic [pgc_pkg::REM_W-1:0] r;
    logic [pgc_pkg::WIDE_W-1:0] d;
    logic [pgc_pkg::WIDE_W-1:0] q;
    r = rem;
    d = dvd;
    q = quo;
    for (int i = 0; i < pgc_pkg::DIV_RADIX_BITS; i++) begin
      t = {r, d[pgc_pkg::WIDE_W-1]};
      d = {d[pgc_pkg::WIDE_W-2:0], 1'b0};
      if (t >= pgc_pkg::DIVISOR) begin
        t = t - pgc_pkg::DIVISOR;
        q = {q[pgc_pkg::WIDE_W-2:0], 1'b1};
      end else begin
        q = {q[pgc_pkg::WIDE_W-2:0], 1'b0};
      end
      r = t[pgc_pkg::REM_W-1:0];
    end
    rem_next = r;
    dvd_next = d;
    quo_next = q;
  end

  // A negative dividend is divided in ones' complement, which makes the
  // complemented quotient equal to the floor.
  always_comb begin
    quot_s     = neg ? ~quo : quo;
    sum16      = {{(pgc_pkg::WIDE_W - pgc_pkg::PSUM_W){psum[pgc_pkg::PSUM_W-1]}}, psum}
               + quot_s;
    drive_wide = sum16[pgc_pkg::WIDE_W-1:8];
    drive_fits = (drive_wide[pgc_pkg::WIDE_W-9:pgc_pkg::DRIVE_W-1] == '0)
              || (drive_wide[pgc_pkg::WIDE_W-9:pgc_pkg::DRIVE_W-1] == '1);
    if (drive_fits) begin
      drive_next = drive_wide[pgc_pkg::DRIVE_W-1:0];
    end else begin
      drive_next = drive_wide[pgc_pkg::WIDE_W-9] ? pgc_pkg::DRIVE_MIN : pgc_pkg::DRIVE_MAX;
    end
    sat_next = sat | !drive_fits;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      integral_acc <= '0;
    end else if (ctrl.op == pgc_pkg::OP_INTEG) begin
      integral_acc <= acc_next;
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    case (ctrl.op)
      pgc_pkg::OP_LOAD: begin
        err  <= {measured_angle[15], measured_angle} - {target_angle[15], target_angle};
        ms   <= elapsed_ms;
        rate <= measured_rate;
        sat  <= 1'b0;
      end
      pgc_pkg::OP_INTEG: begin
        sat <= acc_ovf;
      end
      pgc_pkg::OP_PSUM_LOAD: begin
        psum <= prod[pgc_pkg::PSUM_W-1:0];
      end
      pgc_pkg::OP_PSUM_ADD: begin
        psum <= psum + prod[pgc_pkg::PSUM_W-1:0];
      end
      pgc_pkg::OP_W_LOAD: begin
        wide <= {{(pgc_pkg::WIDE_W - pgc_pkg::PROD_W){prod[pgc_pkg::PROD_W-1]}}, prod};
      end
      pgc_pkg::OP_W_ADDHI: begin
        wide <= wide + {prod[pgc_pkg::WIDE_W-pgc_pkg::ACC_SPLIT-1:0],
                        {pgc_pkg::ACC_SPLIT{1'b0}}};
      end
      pgc_pkg::OP_DIV_START: begin
        neg <= wide[pgc_pkg::WIDE_W-1];
        dvd <= wide[pgc_pkg::WIDE_W-1] ? ~wide : wide;
        quo <= '0;
        rem <= '0;
      end
      pgc_pkg::OP_DIV_STEP: begin
        dvd <= dvd_next;
        quo <= quo_next;
        rem <= rem_next;
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- rtl/core/pid_gimbal_controller.sv -----
// ============================================================================
// pid_gimbal_controller: fixed-point PID controller for a gimbal axis
// Microcoded sequencer over a shared multiplier and a divide-by-1000 unit.
// ============================================================================
// A new sample is taken only after the previous one has passed through the
// whole sequence: the seven radix-256 steps of the divide by 1000 and the
// five passes through the one multiplier. A finished word waits in the
// output register; the sequence goes on with the next sample and holds at
// its last step until that register can receive the following result.
// Reset clears the integral, the gain and setpoint registers and the sequencer.
module pid_gimbal_controller (
  input  logic        clk,
  input  logic        rst,
  pgc_cfg_if.sink     cfg,
  pgc_in_if.sink      sample,
  pgc_out_if.source   result
);

  logic signed [pgc_pkg::GAIN_W-1:0]   p_gain;
  logic signed [pgc_pkg::GAIN_W-1:0]   i_gain;
  logic signed [pgc_pkg::GAIN_W-1:0]   d_gain;
  logic signed [pgc_pkg::ANGLE_W-1:0]  target_angle;

  logic [pgc_pkg::STEP_W-1:0]          step;
  logic [pgc_pkg::STEP_W-1:0]          step_next;
  logic [pgc_pkg::LOOP_W-1:0]          loop_cnt;
  logic                                out_valid;
  logic signed [pgc_pkg::DRIVE_W-1:0]  drive_reg;
  logic                                sat_reg;

  pgc_pkg::ctrl_word_t                 ctrl_raw;
  pgc_pkg::ctrl_word_t                 ctrl;
  logic                                stall;
  logic                                out_free;
  logic signed [pgc_pkg::DRIVE_W-1:0]  drive_next;
  logic                                sat_next;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_gain       <= '0;
      i_gain       <= '0;
      d_gain       <= '0;
      target_angle <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        pgc_pkg::REG_P_GAIN:       p_gain       <= cfg.data;
        pgc_pkg::REG_I_GAIN:       i_gain       <= cfg.data;
        pgc_pkg::REG_D_GAIN:       d_gain       <= cfg.data;
        pgc_pkg::REG_TARGET_ANGLE: target_angle <= cfg.data;
        default: begin
        end
      endcase
    end
  end

  assign ctrl_raw     = pgc_pkg::ucode(step);
  assign out_free     = !out_valid || result.ready;
  assign sample.ready = ctrl_raw.jmp == pgc_pkg::JMP_WAIT_IN;

  always_comb begin
    case (ctrl_raw.jmp)
      pgc_pkg::JMP_WAIT_IN:  stall = !sample.valid;
      pgc_pkg::JMP_WAIT_OUT: stall = !out_free;
      default:               stall = 1'b0;
    endcase
    ctrl = ctrl_raw;
    if (stall) begin
      ctrl.op      = pgc_pkg::OP_NONE;
      ctrl.ld_loop = 1'b0;
    end
  end

  always_comb begin
    if (stall) begin
      step_next = step;
    end else begin
      case (ctrl_raw.jmp)
        pgc_pkg::JMP_LOOP:     step_next = (loop_cnt != '0) ? ctrl_raw.target : step + 1'b1;
        pgc_pkg::JMP_WAIT_OUT: step_next = ctrl_raw.target;
        default:               step_next = step + 1'b1;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= '0;
      loop_cnt  <= '0;
      out_valid <= 1'b0;
    end else begin
      step <= step_next;
      if (ctrl.ld_loop) begin
        loop_cnt <= pgc_pkg::LOOP_W'(pgc_pkg::DIV_DIGITS - 1);
      end else if (ctrl_raw.jmp == pgc_pkg::JMP_LOOP && loop_cnt != '0) begin
        loop_cnt <= loop_cnt - 1'b1;
      end
      if (ctrl.op == pgc_pkg::OP_FINISH) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.op == pgc_pkg::OP_FINISH) begin
      drive_reg <= drive_next;
      sat_reg   <= sat_next;
    end
  end

  assign result.valid     = out_valid;
  assign result.drive_out = drive_reg;
  assign result.saturated = sat_reg;

  pgc_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .ctrl           (ctrl),
    .p_gain         (p_gain),
    .i_gain         (i_gain),
    .d_gain         (d_gain),
    .target_angle   (target_angle),
    .measured_angle (sample.measured_angle),
    .measured_rate  (sample.measured_rate),
    .elapsed_ms     (sample.elapsed_ms),
    .drive_next     (drive_next),
    .sat_next       (sat_next)
  );

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// ============================================================================
// tb: self-checking testbench for pid_gimbal_controller
// Drives samples through bursts and gaps against a stalling receiver. Each
// result word is checked against a bit-exact PID predictor kept in step with
// every accepted sample and every register write.
// ============================================================================
module tb;
  import pgc_pkg::*;

  localparam int CYCLE_LIMIT   = 2_000_000;
  localparam int SETTLE_CYCLES = 24;
  localparam int HOLD_CYCLES   = 400;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_ITEMS   = 125;
  localparam int CLAMP_ROUNDS  = 30_000;

  localparam longint INTEG_MAX = 64'sd549755813887;
  localparam longint INTEG_MIN = -INTEG_MAX - 1;
  localparam longint DRIVE_HI  = 64'sd8388607;
  localparam longint DRIVE_LO  = -64'sd8388608;

  typedef struct packed {
    logic signed [DRIVE_W-1:0] drive;
    logic                      sat;
  } drive_word_t;

  typedef enum {RX_OPEN, RX_COIN, RX_SLOW, RX_BEAT} rx_mode_e;

  logic clk = 1'b0;
  logic rst;

  pgc_cfg_if cfg_bus ();
  pgc_in_if  sample_bus ();
  pgc_out_if result_bus ();

  pid_gimbal_controller dut (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_bus),
    .sample (sample_bus),
    .result (result_bus)
  );

  always #1 clk = ~clk;

  // Predictor state: gains, setpoint and the deg*ms integral.
  logic signed [GAIN_W-1:0] kp, ki, kd, setpoint;
  longint integ;

  drive_word_t drive_q[$];
  int  fail_count  = 0;
  int  cycle_count = 0;
  int  burst_left  = 0;
  logic rx_hold;
  logic fast;

  function automatic longint floor_div_1000(input longint n);
    longint q;
    q = n / 1000;
    if (n % 1000 < 0) q = q - 1;
    return q;
  endfunction

  // Advances the integral and returns the word the block must produce.
  function automatic drive_word_t pid_step(input logic signed [ANGLE_W-1:0] angle,
                                           input logic signed [RATE_W-1:0] rate,
                                           input logic [MS_W-1:0] ms);
    drive_word_t w;
    longint err, acc, sum, drv;
    bit sat;
    sat = 1'b0;
    err = longint'(angle) - longint'(setpoint);
    acc = integ + err * longint'(ms);
    if (acc > INTEG_MAX) begin
      acc = INTEG_MAX;
      sat = 1'b1;
    end
    if (acc < INTEG_MIN) begin
      acc = INTEG_MIN;
      sat = 1'b1;
    end
    integ = acc;
    sum = longint'(kp) * err + longint'(kd) * longint'(rate)
        + floor_div_1000(longint'(ki) * acc);
    drv = sum >>> 8;
    if (drv > DRIVE_HI) begin
      drv = DRIVE_HI;
      sat = 1'b1;
    end
    if (drv < DRIVE_LO) begin
      drv = DRIVE_LO;
      sat = 1'b1;
    end
    w.drive = drv[DRIVE_W-1:0];
    w.sat   = sat;
    return w;
  endfunction

  function automatic logic [15:0] pick_word(input bit wide);
    int sel;
    sel = $urandom_range(0, 7);
    if (!wide || sel == 3 || sel == 4) return 16'($urandom_range(0, 511) - 256);
    case (sel)
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic logic [MS_W-1:0] pick_ms();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2, 3:    return MS_W'($urandom_range(1, 20));
      default: return MS_W'($urandom_range(0, 1023));
    endcase
  endfunction

  // Timeout watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  // Receiver: switches between stall patterns, each kept for a random run.
  initial begin
    rx_mode_e rx_mode;
    int rx_left;
    int rx_phase;
    rx_mode  = RX_OPEN;
    rx_left  = 0;
    rx_phase = 0;
    result_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_left == 0) begin
        rx_mode = rx_mode_e'($urandom_range(0, 3));
        rx_left = $urandom_range(20, 200);
      end
      rx_left  = rx_left - 1;
      rx_phase = rx_phase + 1;
      if (rx_hold) begin
        result_bus.ready <= 1'b0;
      end else if (fast) begin
        result_bus.ready <= 1'b1;
      end else begin
        case (rx_mode)
          RX_OPEN: result_bus.ready <= 1'b1;
          RX_COIN: result_bus.ready <= 1'($urandom_range(0, 1));
          RX_SLOW: result_bus.ready <= ($urandom_range(0, 3) == 0);
          default: result_bus.ready <= ((rx_phase % 5) < 2);
        endcase
      end
    end
  end

  // Result checker.
  always @(posedge clk) begin
    drive_word_t want;
    if (!rst && result_bus.valid && result_bus.ready) begin
      if (drive_q.size() == 0) begin
        $error("result word with no sample pending: drive_out %0d", result_bus.drive_out);
        fail_count++;
      end else begin
        want = drive_q.pop_front();
        if (result_bus.drive_out !== want.drive) begin
          $error("drive_out: expected %0d, got %0d", want.drive, result_bus.drive_out);
          fail_count++;
        end
        if (result_bus.saturated !== want.sat) begin
          $error("saturated: expected %0d, got %0d", want.sat, result_bus.saturated);
          fail_count++;
        end
      end
    end
  end

  // Sends one sample word; the valid stays high for a following word.
  task automatic send_sample(input logic signed [ANGLE_W-1:0] angle,
                             input logic signed [RATE_W-1:0] rate,
                             input logic [MS_W-1:0] ms);
    int gap;
    if (!fast && burst_left == 0) begin
      gap = $urandom_range(0, 10);
      if (gap > 0) begin
        sample_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(1, 6);
    end
    sample_bus.valid          <= 1'b1;
    sample_bus.measured_angle <= angle;
    sample_bus.measured_rate  <= rate;
    sample_bus.elapsed_ms     <= ms;
    do @(posedge clk); while (!sample_bus.ready);
    drive_q.push_back(pid_step(angle, rate, ms));
    if (burst_left > 0) burst_left--;
  endtask

  // Waits until every result word has come back and the block is quiet.
  task automatic settle();
    sample_bus.valid <= 1'b0;
    while (drive_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [GAIN_W-1:0] val);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    do @(posedge clk); while (!cfg_bus.ready);
    case (idx)
      REG_P_GAIN:       kp       = val;
      REG_I_GAIN:       ki       = val;
      REG_D_GAIN:       kd       = val;
      REG_TARGET_ANGLE: setpoint = val;
      default: ;
    endcase
  endtask

  task automatic configure(input logic [GAIN_W-1:0] p, input logic [GAIN_W-1:0] i,
                           input logic [GAIN_W-1:0] d, input logic [GAIN_W-1:0] t);
    settle();
    write_reg(REG_P_GAIN, p);
    write_reg(REG_I_GAIN, i);
    write_reg(REG_D_GAIN, d);
    write_reg(REG_TARGET_ANGLE, t);
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic test_directed();
    // Largest gains, setpoint at its floor: drive clamps at its upper bound.
    configure(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000);
    send_sample(16'sh7FFF, 16'sh7FFF, 10'd0);
    send_sample(16'sh8000, 16'sh8000, 10'd0);
    send_sample(16'sh7FFF, 16'sh0000, 10'd1023);
    send_sample(16'sh8000, 16'sh7FFF, 10'd1023);
    send_sample(16'sh0000, 16'sh0000, 10'd0);
    configure(16'h8000, 16'h8000, 16'h8000, 16'h7FFF);
    send_sample(16'sh8000, 16'sh8000, 10'd1023);
    send_sample(16'sh7FFF, 16'sh7FFF, 10'd1023);
    send_sample(16'sh0000, 16'sh8000, 10'd512);
    send_sample(16'sh7FFF, 16'sh0001, 10'd0);
    configure(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_sample(16'sh7FFF, 16'sh7FFF, 10'd1023);
    send_sample(16'sh8000, 16'sh8000, 10'd1);
    // Unit gains, where the flooring of negative terms shows up.
    configure(16'h0100, 16'h0100, 16'h0100, 16'h0000);
    send_sample(16'sh0100, 16'sh0000, 10'd1);
    send_sample(16'shFF00, 16'sh0080, 10'd3);
    send_sample(16'sh0001, 16'shFFFF, 10'd999);
    send_sample(16'shFFFF, 16'sh0001, 10'd1000);
    send_sample(16'shFFFF, 16'shFFFF, 10'd0);
  endtask

  task automatic test_random();
    bit wide;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      wide = (ph >= 2);
      case (ph)
        4:       configure(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        5:       configure(16'h8000, 16'h8000, 16'h8000, 16'h8000);
        default: configure(pick_word(wide), pick_word(wide), pick_word(wide), pick_word(1'b1));
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_sample(pick_word(1'b1), pick_word(1'b1), pick_ms());
      end
    end
  endtask

  // The receiver holds off while samples keep coming, so the block backs up.
  task automatic test_backpressure();
    configure(pick_word(1'b0), pick_word(1'b0), pick_word(1'b0), pick_word(1'b1));
    fork
      begin
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
      end
    join_none
    for (int n = 0; n < 24; n++) begin
      send_sample(pick_word(1'b1), pick_word(1'b1), pick_ms());
    end
  endtask

  // Drives the integral into its upper clamp, then all the way to the lower one.
  task automatic test_integral_clamp();
    int hits;
    configure(16'h0001, 16'h0003, 16'h0001, 16'h8000);
    fast <= 1'b1;
    hits = 0;
    for (int n = 0; n < CLAMP_ROUNDS && hits < 8; n++) begin
      send_sample(16'sh7FFF, pick_word(1'b1), 10'd1023);
      if (integ == INTEG_MAX) hits++;
    end
    configure(16'h0001, 16'h0003, 16'h0001, 16'h7FFF);
    hits = 0;
    for (int n = 0; n < CLAMP_ROUNDS && hits < 8; n++) begin
      send_sample(16'sh8000, pick_word(1'b1), 10'd1023);
      if (integ == INTEG_MIN) hits++;
    end
    fast <= 1'b0;
  endtask

  initial begin
    kp       = '0;
    ki       = '0;
    kd       = '0;
    setpoint = '0;
    integ    = 0;
    rst                       <= 1'b1;
    rx_hold                   <= 1'b0;
    fast                      <= 1'b0;
    cfg_bus.valid             <= 1'b0;
    cfg_bus.index             <= '0;
    cfg_bus.data              <= '0;
    sample_bus.valid          <= 1'b0;
    sample_bus.measured_angle <= '0;
    sample_bus.measured_rate  <= '0;
    sample_bus.elapsed_ms     <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_random();
    test_backpressure();
    test_integral_clamp();

    settle();
    if (fail_count == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/pgc_pkg.sv
rtl/core/pgc_cfg_if.sv
rtl/core/pgc_in_if.sv
rtl/core/pgc_out_if.sv
rtl/core/pgc_datapath.sv
rtl/core/pid_gimbal_controller.sv
test/tb.sv
